// ----- hdl/sccb_rm_pkg.sv -----
package sccb_rm_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Register map: byte address bit 2 selects the register slot.
  localparam logic REG_QUARTER_TICKS = 1'b0;

  localparam logic [15:0] QUARTER_TICKS_RESET = 16'd500;

  // Longest read burst; larger read counts are clipped to it.
  localparam logic [8:0] MAX_READ = 9'd256;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_TX_DEVW,
    PH_ACK_DEVW,
    PH_TX_REG,
    PH_ACK_REG,
    PH_TX_DATA,
    PH_ACK_DATA,
    PH_STOP_MID,
    PH_START_B,
    PH_TX_DEVR,
    PH_ACK_DEVR,
    PH_RX,
    PH_MACK,
    PH_STOP_END
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [8:0] read_count;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_last;
    logic       done_res;
    logic       fail_status;
  } res_t;

  function automatic logic is_tx(phase_t p);
    return (p == PH_TX_DEVW) || (p == PH_TX_REG) || (p == PH_TX_DATA) || (p == PH_TX_DEVR);
  endfunction

  function automatic logic is_sack(phase_t p);
    return (p == PH_ACK_DEVW) || (p == PH_ACK_REG) || (p == PH_ACK_DATA) ||
           (p == PH_ACK_DEVR);
  endfunction

endpackage

// ----- hdl/sccb_rm_ifs.sv -----
interface sccb_req_if;
  logic               valid;
  logic               ready;
  sccb_rm_pkg::req_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sccb_res_if;
  logic               valid;
  logic               ready;
  sccb_rm_pkg::res_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/sccb_register_master_unit.sv -----
// A request or tick is reflected in the result register in the cycle after acceptance.
// Throughput: one item per cycle unless stalled; the sequencer takes one tick step per accepted item.
// The input is stalled only while a finished result waits in the output register.
// Reset (synchronous, active high) returns the sequencer to idle with the clock and data
// lines released high, clears the result valid flag and sets quarter_ticks to 500.
module sccb_register_master_unit (
  input  logic              clk,
  input  logic              rst,
  sccb_req_if.sink          req,
  sccb_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  sccb_rm_pkg::phase_t phase, phase_next;
  logic [15:0] qticks;
  logic [15:0] qcount, qcount_next;
  logic [1:0]  qstep, qstep_next;
  logic [2:0]  bit_idx, bit_idx_next;
  logic [7:0]  shift, shift_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic        ack_all, ack_all_next;
  logic [6:0]  held_dev, held_dev_next;
  logic [7:0]  held_reg, held_reg_next;
  logic [7:0]  held_data, held_data_next;
  logic        is_read, is_read_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        sda_oe, sda_oe_next;

  sccb_rm_pkg::res_t res_next;
  logic              acc;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sccb_rm_pkg::REG_QUARTER_TICKS) ? {16'd0, qticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      qticks <= sccb_rm_pkg::QUARTER_TICKS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == sccb_rm_pkg::REG_QUARTER_TICKS)) begin
      qticks <= pwdata[15:0];
    end
  end

  assign req.ready = !res.valid || res.ready;
  assign acc       = req.valid && req.ready;

  always_comb begin
    logic [16:0] cnt_inc;
    logic        slot_done;
    logic [8:0]  cnt;

    phase_next      = phase;
    qcount_next     = qcount;
    qstep_next      = qstep;
    bit_idx_next    = bit_idx;
    shift_next      = shift;
    bytes_left_next = bytes_left;
    ack_all_next    = ack_all;
    held_dev_next   = held_dev;
    held_reg_next   = held_reg;
    held_data_next  = held_data;
    is_read_next    = is_read;
    scl_next        = scl;
    sda_next        = sda;
    sda_oe_next     = sda_oe;
    res_next        = '0;
    cnt_inc         = 17'd0;
    slot_done       = 1'b0;
    cnt             = 9'd0;

    if (acc) begin
      unique case (req.data.req_type)
        sccb_rm_pkg::REQ_TICK: begin
          if (phase != sccb_rm_pkg::PH_IDLE) begin
            if (qcount == 16'd0) begin
              // Pin action on the first tick of each quarter.
              if ((phase == sccb_rm_pkg::PH_START_A) || (phase == sccb_rm_pkg::PH_START_B)) begin
                if (qstep == 2'd1) begin
                  sda_next    = 1'b0;
                  sda_oe_next = 1'b1;
                end else if (qstep == 2'd3) begin
                  scl_next = 1'b0;
                end
              end else if ((phase == sccb_rm_pkg::PH_STOP_MID) ||
                           (phase == sccb_rm_pkg::PH_STOP_END)) begin
                if (qstep == 2'd0) begin
                  sda_next    = 1'b0;
                  sda_oe_next = 1'b1;
                end else if (qstep == 2'd1) begin
                  scl_next = 1'b1;
                end else if (qstep == 2'd3) begin
                  sda_next = 1'b1;
                end
              end else begin
                if (qstep == 2'd0) begin
                  if (sccb_rm_pkg::is_tx(phase)) begin
                    sda_next    = shift[7];
                    sda_oe_next = 1'b1;
                  end else if (phase == sccb_rm_pkg::PH_MACK) begin
                    // ACK while more bytes follow, NACK after the last one.
                    sda_next    = (bytes_left == 9'd0);
                    sda_oe_next = 1'b1;
                  end else begin
                    sda_oe_next = 1'b0;
                  end
                end else if (qstep == 2'd1) begin
                  scl_next = 1'b1;
                end else if (qstep == 2'd3) begin
                  scl_next = 1'b0;
                end
              end

              // Sample the data line while the clock is high.
              if (qstep == 2'd2) begin
                if (sccb_rm_pkg::is_sack(phase)) begin
                  if (req.data.sda_in) begin
                    ack_all_next = 1'b0;
                  end
                end else if (phase == sccb_rm_pkg::PH_RX) begin
                  shift_next = {shift[6:0], req.data.sda_in};
                  if (bit_idx == 3'd7) begin
                    res_next.byte_valid = 1'b1;
                    res_next.byte_data  = shift_next;
                    res_next.byte_last  = (bytes_left == 9'd1);
                    if (bytes_left != 9'd0) begin
                      bytes_left_next = bytes_left - 9'd1;
                    end
                  end
                end
              end
            end

            cnt_inc = {1'b0, qcount} + 17'd1;
            if (cnt_inc >= {1'b0, qticks}) begin
              qcount_next = 16'd0;
              if (qstep == 2'd3) begin
                qstep_next = 2'd0;
                slot_done  = 1'b1;
                if (sccb_rm_pkg::is_tx(phase) || (phase == sccb_rm_pkg::PH_RX)) begin
                  if (sccb_rm_pkg::is_tx(phase)) begin
                    shift_next = {shift_next[6:0], 1'b0};
                  end
                  if (bit_idx != 3'd7) begin
                    bit_idx_next = bit_idx + 3'd1;
                    slot_done    = 1'b0;
                  end
                end
                if (slot_done) begin
                  bit_idx_next = 3'd0;
                  unique case (phase)
                    sccb_rm_pkg::PH_START_A: begin
                      phase_next = sccb_rm_pkg::PH_TX_DEVW;
                      shift_next = {held_dev, 1'b0};
                    end
                    sccb_rm_pkg::PH_TX_DEVW: phase_next = sccb_rm_pkg::PH_ACK_DEVW;
                    sccb_rm_pkg::PH_ACK_DEVW: begin
                      phase_next = sccb_rm_pkg::PH_TX_REG;
                      shift_next = held_reg;
                    end
                    sccb_rm_pkg::PH_TX_REG: phase_next = sccb_rm_pkg::PH_ACK_REG;
                    sccb_rm_pkg::PH_ACK_REG: begin
                      if (is_read) begin
                        phase_next = sccb_rm_pkg::PH_STOP_MID;
                      end else begin
                        phase_next = sccb_rm_pkg::PH_TX_DATA;
                        shift_next = held_data;
                      end
                    end
                    sccb_rm_pkg::PH_TX_DATA: phase_next = sccb_rm_pkg::PH_ACK_DATA;
                    sccb_rm_pkg::PH_ACK_DATA: phase_next = sccb_rm_pkg::PH_STOP_END;
                    sccb_rm_pkg::PH_STOP_MID: phase_next = sccb_rm_pkg::PH_START_B;
                    sccb_rm_pkg::PH_START_B: begin
                      phase_next = sccb_rm_pkg::PH_TX_DEVR;
                      shift_next = {held_dev, 1'b1};
                    end
                    sccb_rm_pkg::PH_TX_DEVR: phase_next = sccb_rm_pkg::PH_ACK_DEVR;
                    sccb_rm_pkg::PH_ACK_DEVR, sccb_rm_pkg::PH_MACK: begin
                      if (bytes_left_next != 9'd0) begin
                        phase_next = sccb_rm_pkg::PH_RX;
                        shift_next = 8'd0;
                      end else begin
                        phase_next = sccb_rm_pkg::PH_STOP_END;
                      end
                    end
                    sccb_rm_pkg::PH_RX: phase_next = sccb_rm_pkg::PH_MACK;
                    sccb_rm_pkg::PH_STOP_END: begin
                      phase_next           = sccb_rm_pkg::PH_IDLE;
                      res_next.done_res    = 1'b1;
                      res_next.fail_status = !ack_all_next;
                    end
                    default: phase_next = sccb_rm_pkg::PH_IDLE;
                  endcase
                end
              end else begin
                qstep_next = qstep + 2'd1;
              end
            end else begin
              qcount_next = cnt_inc[15:0];
            end
          end
        end
        sccb_rm_pkg::REQ_WRITE, sccb_rm_pkg::REQ_READ: begin
          if (phase == sccb_rm_pkg::PH_IDLE) begin
            cnt = (req.data.read_count > sccb_rm_pkg::MAX_READ) ?
                  sccb_rm_pkg::MAX_READ : req.data.read_count;
            held_dev_next   = req.data.device_addr;
            held_reg_next   = req.data.reg_addr;
            held_data_next  = req.data.write_data;
            is_read_next    = (req.data.req_type == sccb_rm_pkg::REQ_READ);
            bytes_left_next = is_read_next ? cnt : 9'd0;
            ack_all_next    = 1'b1;
            shift_next      = 8'd0;
            bit_idx_next    = 3'd0;
            qstep_next      = 2'd0;
            qcount_next     = 16'd0;
            phase_next      = sccb_rm_pkg::PH_START_A;
          end
        end
        default: ;
      endcase
    end

    res_next.scl_level = scl_next;
    res_next.sda_level = sda_next;
    res_next.sda_drive = sda_oe_next;
    res_next.busy_res  = (phase_next != sccb_rm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= sccb_rm_pkg::PH_IDLE;
      qcount     <= 16'd0;
      qstep      <= 2'd0;
      bit_idx    <= 3'd0;
      shift      <= 8'd0;
      bytes_left <= 9'd0;
      ack_all    <= 1'b1;
      held_dev   <= 7'd0;
      held_reg   <= 8'd0;
      held_data  <= 8'd0;
      is_read    <= 1'b0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      sda_oe     <= 1'b0;
    end else begin
      phase      <= phase_next;
      qcount     <= qcount_next;
      qstep      <= qstep_next;
      bit_idx    <= bit_idx_next;
      shift      <= shift_next;
      bytes_left <= bytes_left_next;
      ack_all    <= ack_all_next;
      held_dev   <= held_dev_next;
      held_reg   <= held_reg_next;
      held_data  <= held_data_next;
      is_read    <= is_read_next;
      scl        <= scl_next;
      sda        <= sda_next;
      sda_oe     <= sda_oe_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (acc) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res.data <= res_next;
    end
  end

  // A received byte is reported only from the receive slot, which ends when the following quarter is over.
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.byte_valid) |-> (phase == sccb_rm_pkg::PH_RX))
    else $error("byte reported outside the receive slot");

  // The busy flag of the pending result always matches the live sequencer state.
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.busy_res == (phase != sccb_rm_pkg::PH_IDLE)))
    else $error("busy flag disagrees with sequencer state");

  // The quarter counter stays inside the configured period during a transaction.
  assert property (@(posedge clk) disable iff (rst)
    (phase != sccb_rm_pkg::PH_IDLE) |-> ((qcount == 16'd0) || (qcount < qticks)))
    else $error("quarter counter out of range");

  // Done is only reported when the sequencer returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    (acc && res_next.done_res) |=> (phase == sccb_rm_pkg::PH_IDLE))
    else $error("done without return to idle");

endmodule

// ----- verif/tb_sccb_register_master_unit.sv -----
`timescale 1ns / 1ps

module tb_sccb_register_master_unit;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [2:0] QT_ADDR = {sccb_rm_pkg::REG_QUARTER_TICKS, 2'b00};
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_TRANSACTIONS = 2;
  localparam int TAIL_TICKS = 30;

  // Line levels right after reset, and right after a request is latched.
  localparam sccb_rm_pkg::res_t LINES_IDLE =
    {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};
  localparam sccb_rm_pkg::res_t LINES_LATCHED =
    {1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0};

  typedef enum logic [1:0] {
    SLAVE_ACKS,
    SLAVE_RANDOM,
    SLAVE_ABSENT
  } slave_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [6:0]        dev;
    logic [7:0]        regad;
    logic [7:0]        wdata;
    logic [8:0]        cnt;
    slave_t            slave;
    logic              typed;
    sccb_rm_pkg::res_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 3;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sccb_req_if req_ch ();
  sccb_res_if res_ch ();

  sccb_register_master_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Shadow of the sequencer, advanced once per accepted input transaction.
  sccb_rm_pkg::phase_t seq_phase;
  int          quarter_cnt;
  logic [1:0]  quarter_idx;
  logic [3:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [8:0]  bytes_to_go;
  logic        all_acked;
  logic [6:0]  dev_hold;
  logic [7:0]  reg_hold;
  logic [7:0]  data_hold;
  logic        reading;
  logic        scl_q;
  logic        sda_q;
  logic        drive_q;
  logic [15:0] qt_cfg;

  sccb_rm_pkg::res_t expected_res_q[$];
  int   fail_count;
  int   cycle_count;
  bit   hold_results;
  bit   send_quiet;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic sends_byte(sccb_rm_pkg::phase_t p);
    return p inside {sccb_rm_pkg::PH_TX_DEVW, sccb_rm_pkg::PH_TX_REG,
                     sccb_rm_pkg::PH_TX_DATA, sccb_rm_pkg::PH_TX_DEVR};
  endfunction

  function automatic logic takes_ack(sccb_rm_pkg::phase_t p);
    return p inside {sccb_rm_pkg::PH_ACK_DEVW, sccb_rm_pkg::PH_ACK_REG,
                     sccb_rm_pkg::PH_ACK_DATA, sccb_rm_pkg::PH_ACK_DEVR};
  endfunction

  function automatic void shadow_reset();
    seq_phase = sccb_rm_pkg::PH_IDLE;
    quarter_cnt = 0;
    quarter_idx = 2'd0;
    bit_cnt = 4'd0;
    shifter = 8'h00;
    bytes_to_go = 9'd0;
    all_acked = 1'b1;
    dev_hold = 7'd0;
    reg_hold = 8'd0;
    data_hold = 8'd0;
    reading = 1'b0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    drive_q = 1'b0;
    qt_cfg = sccb_rm_pkg::QUARTER_TICKS_RESET;
  endfunction

  function automatic void drive_pins();
    if (seq_phase == sccb_rm_pkg::PH_START_A || seq_phase == sccb_rm_pkg::PH_START_B) begin
      if (quarter_idx == 2'd1) begin
        sda_q = 1'b0;
        drive_q = 1'b1;
      end else if (quarter_idx == 2'd3) begin
        scl_q = 1'b0;
      end
    end else if (seq_phase == sccb_rm_pkg::PH_STOP_MID ||
                 seq_phase == sccb_rm_pkg::PH_STOP_END) begin
      if (quarter_idx == 2'd0) begin
        sda_q = 1'b0;
        drive_q = 1'b1;
      end else if (quarter_idx == 2'd1) begin
        scl_q = 1'b1;
      end else if (quarter_idx == 2'd3) begin
        sda_q = 1'b1;
      end
    end else begin
      case (quarter_idx)
        2'd0: begin
          if (sends_byte(seq_phase)) begin
            sda_q = shifter[7];
            drive_q = 1'b1;
          end else if (seq_phase == sccb_rm_pkg::PH_MACK) begin
            // Acknowledge while more bytes follow, not-acknowledge after the last.
            sda_q = (bytes_to_go == 9'd0);
            drive_q = 1'b1;
          end else begin
            drive_q = 1'b0;
          end
        end
        2'd1: scl_q = 1'b1;
        2'd3: scl_q = 1'b0;
        default: ;
      endcase
    end
  endfunction

  function automatic void sample_line(logic sda, inout sccb_rm_pkg::res_t r);
    if (quarter_idx != 2'd2) return;
    if (takes_ack(seq_phase)) begin
      if (sda) all_acked = 1'b0;
    end else if (seq_phase == sccb_rm_pkg::PH_RX) begin
      shifter = {shifter[6:0], sda};
      if (bit_cnt == 4'd7) begin
        r.byte_valid = 1'b1;
        r.byte_data = shifter;
        r.byte_last = (bytes_to_go == 9'd1);
        if (bytes_to_go != 9'd0) bytes_to_go = bytes_to_go - 9'd1;
      end
    end
  endfunction

  function automatic void finish_slot(inout sccb_rm_pkg::res_t r);
    if (sends_byte(seq_phase) || seq_phase == sccb_rm_pkg::PH_RX) begin
      if (sends_byte(seq_phase)) shifter = shifter << 1;
      if (bit_cnt < 4'd7) begin
        bit_cnt = bit_cnt + 4'd1;
        return;
      end
    end
    bit_cnt = 4'd0;
    case (seq_phase)
      sccb_rm_pkg::PH_START_A: begin
        seq_phase = sccb_rm_pkg::PH_TX_DEVW;
        shifter = {dev_hold, 1'b0};
      end
      sccb_rm_pkg::PH_TX_DEVW: seq_phase = sccb_rm_pkg::PH_ACK_DEVW;
      sccb_rm_pkg::PH_ACK_DEVW: begin
        seq_phase = sccb_rm_pkg::PH_TX_REG;
        shifter = reg_hold;
      end
      sccb_rm_pkg::PH_TX_REG: seq_phase = sccb_rm_pkg::PH_ACK_REG;
      sccb_rm_pkg::PH_ACK_REG: begin
        if (reading) begin
          seq_phase = sccb_rm_pkg::PH_STOP_MID;
        end else begin
          seq_phase = sccb_rm_pkg::PH_TX_DATA;
          shifter = data_hold;
        end
      end
      sccb_rm_pkg::PH_TX_DATA: seq_phase = sccb_rm_pkg::PH_ACK_DATA;
      sccb_rm_pkg::PH_ACK_DATA: seq_phase = sccb_rm_pkg::PH_STOP_END;
      sccb_rm_pkg::PH_STOP_MID: seq_phase = sccb_rm_pkg::PH_START_B;
      sccb_rm_pkg::PH_START_B: begin
        seq_phase = sccb_rm_pkg::PH_TX_DEVR;
        shifter = {dev_hold, 1'b1};
      end
      sccb_rm_pkg::PH_TX_DEVR: seq_phase = sccb_rm_pkg::PH_ACK_DEVR;
      sccb_rm_pkg::PH_ACK_DEVR, sccb_rm_pkg::PH_MACK: begin
        if (bytes_to_go != 9'd0) begin
          seq_phase = sccb_rm_pkg::PH_RX;
          shifter = 8'h00;
        end else begin
          seq_phase = sccb_rm_pkg::PH_STOP_END;
        end
      end
      sccb_rm_pkg::PH_RX: seq_phase = sccb_rm_pkg::PH_MACK;
      sccb_rm_pkg::PH_STOP_END: begin
        seq_phase = sccb_rm_pkg::PH_IDLE;
        r.done_res = 1'b1;
        r.fail_status = !all_acked;
      end
      default: seq_phase = sccb_rm_pkg::PH_IDLE;
    endcase
  endfunction

  function automatic sccb_rm_pkg::res_t predict_item(sccb_rm_pkg::req_t it);
    sccb_rm_pkg::res_t r;
    r = '0;
    if (it.req_type == sccb_rm_pkg::REQ_TICK) begin
      if (seq_phase != sccb_rm_pkg::PH_IDLE) begin
        if (quarter_cnt == 0) begin
          drive_pins();
          sample_line(it.sda_in, r);
        end
        quarter_cnt++;
        if (quarter_cnt >= int'(qt_cfg)) begin
          quarter_cnt = 0;
          if (quarter_idx == 2'd3) begin
            quarter_idx = 2'd0;
            finish_slot(r);
          end else begin
            quarter_idx = quarter_idx + 2'd1;
          end
        end
      end
    end else if ((it.req_type == sccb_rm_pkg::REQ_WRITE ||
                  it.req_type == sccb_rm_pkg::REQ_READ) &&
                 seq_phase == sccb_rm_pkg::PH_IDLE) begin
      dev_hold = it.device_addr;
      reg_hold = it.reg_addr;
      data_hold = it.write_data;
      reading = (it.req_type == sccb_rm_pkg::REQ_READ);
      bytes_to_go = !reading ? 9'd0 :
                    (it.read_count > sccb_rm_pkg::MAX_READ) ? sccb_rm_pkg::MAX_READ :
                    it.read_count;
      all_acked = 1'b1;
      shifter = 8'h00;
      bit_cnt = 4'd0;
      quarter_idx = 2'd0;
      quarter_cnt = 0;
      seq_phase = sccb_rm_pkg::PH_START_A;
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drive_q;
    r.busy_res = (seq_phase != sccb_rm_pkg::PH_IDLE);
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item; returns at the edge where it is accepted.
  task automatic send_item(input sccb_rm_pkg::req_t it, input bit typed = 1'b0,
                           input sccb_rm_pkg::res_t want = '0);
    int gap;
    sccb_rm_pkg::res_t predicted;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    do @(posedge clk); while (!req_ch.ready);
    predicted = predict_item(it);
    expected_res_q.push_back(typed ? want : predicted);
  endtask

  function automatic sccb_rm_pkg::req_t random_fields(logic [1:0] kind);
    sccb_rm_pkg::req_t it;
    it.req_type = kind;
    it.device_addr = 7'($urandom_range(0, 127));
    it.reg_addr = 8'($urandom_range(0, 255));
    it.write_data = 8'($urandom_range(0, 255));
    it.read_count = 9'($urandom_range(0, 511));
    it.sda_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Ticks the sequencer until the running transaction has ended.
  task automatic run_to_idle(input slave_t slave, input bit noise);
    sccb_rm_pkg::req_t it;
    int roll;
    while (seq_phase != sccb_rm_pkg::PH_IDLE) begin
      it = random_fields(sccb_rm_pkg::REQ_TICK);
      case (slave)
        SLAVE_ABSENT: it.sda_in = 1'b1;
        SLAVE_ACKS: if (takes_ack(seq_phase)) it.sda_in = 1'b0;
        default: ;
      endcase
      roll = $urandom_range(0, 99);
      if (noise && roll < 2) it.req_type = REQ_UNUSED;
      else if (noise && roll < 5) begin
        it.req_type = roll[0] ? sccb_rm_pkg::REQ_WRITE : sccb_rm_pkg::REQ_READ;
      end
      send_item(it);
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_quarter_ticks(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= QT_ADDR;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    qt_cfg = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== value) begin
      $display("%0t: quarter_ticks read back expected %0h, got %0h", $time, value,
               prdata[15:0]);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic dir_row_t directed_row(int idx);
    case (idx)
      0: return {sccb_rm_pkg::REQ_TICK, 7'h00, 8'h00, 8'h00, 9'd0, SLAVE_ACKS, 1'b1,
                 LINES_IDLE};
      1: return {REQ_UNUSED, 7'h7f, 8'hff, 8'hff, 9'h1ff, SLAVE_ACKS, 1'b1, LINES_IDLE};
      default: return {sccb_rm_pkg::REQ_READ, 7'h7f, 8'ha5, 8'h5a, 9'd2, SLAVE_RANDOM,
                       1'b1, LINES_LATCHED};
    endcase
  endfunction

  task automatic random_transactions();
    sccb_rm_pkg::req_t it;
    slave_t slave;
    int roll;
    for (int n = 0; n < RANDOM_TRANSACTIONS; n++) begin
      send_quiet = ($urandom_range(0, 3) == 0);
      // Some noise while idle: ticks and the unused request code do nothing.
      repeat ($urandom_range(0, 2)) begin
        send_item(random_fields($urandom_range(0, 1) ? sccb_rm_pkg::REQ_TICK : REQ_UNUSED));
      end
      it = random_fields(n[0] ? sccb_rm_pkg::REQ_READ : sccb_rm_pkg::REQ_WRITE);
      it.read_count = 9'($urandom_range(0, 1));
      roll = $urandom_range(0, 9);
      slave = (roll < 7) ? SLAVE_ACKS : (roll < 9) ? SLAVE_RANDOM : SLAVE_ABSENT;
      if (n == 0) hold_results = 1'b1;
      if (n == 1) begin
        req_ch.valid <= 1'b0;
        while (expected_res_q.size() != 0) @(posedge clk);
      end
      send_item(it);
      run_to_idle(slave, 1'b1);
    end
  endtask

  // Stimulus and prediction.
  initial begin
    dir_row_t row;
    sccb_rm_pkg::req_t it;
    fail_count = 0;
    hold_results = 1'b0;
    send_quiet = 1'b0;
    shadow_reset();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // A zero quarter length runs as one tick per quarter.
    write_quarter_ticks(16'd0);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = directed_row(i);
      it = random_fields(row.kind);
      it.device_addr = row.dev;
      it.reg_addr = row.regad;
      it.write_data = row.wdata;
      it.read_count = row.cnt;
      send_item(it, row.typed, row.want);
      if (row.kind == sccb_rm_pkg::REQ_WRITE || row.kind == sccb_rm_pkg::REQ_READ) begin
        // A second request while busy must be ignored.
        send_item(random_fields(sccb_rm_pkg::REQ_READ));
        run_to_idle(row.slave, 1'b0);
      end
    end
    settle();

    write_quarter_ticks(16'd1);
    random_transactions();
    settle();

    // Several ticks per quarter: the opening slots of one more write.
    write_quarter_ticks(16'd3);
    send_item(random_fields(sccb_rm_pkg::REQ_WRITE));
    repeat (TAIL_TICKS) send_item(random_fields(sccb_rm_pkg::REQ_TICK));

    req_ch.valid <= 1'b0;
    while (expected_res_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int stall_left;
    int quiet_left;
    bit quiet;
    stall_left = 0;
    quiet_left = 0;
    quiet = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        quiet_left = $urandom_range(50, 200);
      end else begin
        quiet_left--;
      end
      if (hold_results) begin
        hold_results = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap(1'b0);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    sccb_rm_pkg::res_t want;
    sccb_rm_pkg::res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (expected_res_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %0h", $time, got);
        fail_count++;
      end else begin
        want = expected_res_q.pop_front();
        if (got !== want) begin
          $display("%0t: result expected %0h, got %0h", $time, want, got);
          fail_count++;
        end
      end
    end
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
